>>> hdl/dxt1_dxt5_block_decoder_top_assert.svh
// assertion macros shared by the checker
`ifndef DXT1_DXT5_BLOCK_DECODER_TOP_ASSERT_SVH
`define DXT1_DXT5_BLOCK_DECODER_TOP_ASSERT_SVH

// antecedent in one cycle implies consequent in the next
`define DBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dbd assertion failed");

// signal holds while a transfer is stalled
`define DBD_ASSERT_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error("dbd stall hold failed");

`endif

>>> hdl/dbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dbd_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PIX_W      = 14;
  localparam int unsigned DIM_W      = 17;
  localparam int unsigned CFG_DIM_W  = 15;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] bcol;
    logic [COORD_W-1:0] brow;
    logic [15:0]        mask;
    logic [31:0]        cidx;
    logic [47:0]        aidx;
    logic               dxt5;
    logic [3:0][7:0]    red;
    logic [3:0][7:0]    green;
    logic [3:0][7:0]    blue;
    logic [3:0][7:0]    apal;
    logic [7:0][7:0]    av;
  } blk_desc_t;

  // x * 255 / 31, truncated
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [31:0] prod;
    prod = 32'(v) * 32'd255 * 32'd8457;
    return prod[25:18];
  endfunction

  // x * 255 / 63, truncated
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [31:0] prod;
    prod = 32'(v) * 32'd255 * 32'd16645;
    return prod[27:20];
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd683;
    return prod[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd3277;
    return prod[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd2341;
    return prod[21:14];
  endfunction

endpackage
`default_nettype wire

>>> hdl/dbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dbd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dbd_pkg::COORD_W-1:0]   block_col_i,
  input  wire logic [dbd_pkg::COORD_W-1:0]   block_row_i,
  input  wire logic [63:0]                   color_half_i,
  input  wire logic [63:0]                   alpha_half_i,
  input  wire logic                          dxt5_i,
  input  wire logic [dbd_pkg::DIM_W-1:0]     width_lim_i,
  input  wire logic [dbd_pkg::DIM_W-1:0]     height_lim_i,
  output logic                               desc_valid_o,
  input  wire logic                          desc_ready_i,
  output dbd_pkg::blk_desc_t                 desc_o
);
  import dbd_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] bcol;
    logic [COORD_W-1:0] brow;
    logic [15:0]        mask;
    logic [31:0]        cidx;
    logic [47:0]        aidx;
    logic               dxt5;
    logic               four;
    logic [2:0][7:0]    e0;
    logic [2:0][7:0]    e1;
    logic [7:0]         a0;
    logic [7:0]         a1;
  } s1_t;

  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q, s1_d;
  logic s1_done;
  logic [3:0] colv, rowv;
  logic [PIX_W-1:0] xc, yc;

  // stage 1: endpoint expansion and clip mask
  always_comb begin
    s1_d.bcol = block_col_i;
    s1_d.brow = block_row_i;
    s1_d.cidx = color_half_i[63:32];
    s1_d.aidx = alpha_half_i[63:16];
    s1_d.dxt5 = dxt5_i;
    s1_d.four = dxt5_i || (color_half_i[15:0] > color_half_i[31:16]);
    s1_d.e0[0] = expand5(color_half_i[15:11]);
    s1_d.e0[1] = expand6(color_half_i[10:5]);
    s1_d.e0[2] = expand5(color_half_i[4:0]);
    s1_d.e1[0] = expand5(color_half_i[31:27]);
    s1_d.e1[1] = expand6(color_half_i[26:21]);
    s1_d.e1[2] = expand5(color_half_i[20:16]);
    s1_d.a0 = alpha_half_i[7:0];
    s1_d.a1 = alpha_half_i[15:8];
    for (int i = 0; i < 4; i++) begin
      xc = {block_col_i, 2'(i)};
      yc = {block_row_i, 2'(i)};
      colv[i] = DIM_W'(xc) < width_lim_i;
      rowv[i] = DIM_W'(yc) < height_lim_i;
    end
    for (int p = 0; p < 16; p++) begin
      s1_d.mask[p] = colv[p % 4] && rowv[p / 4];
    end
  end

  // fully clipped blocks are dropped here
  assign s1_done      = s1_valid_q && ((s1_q.mask == 16'd0) || desc_ready_i);
  assign in_ready_o   = !s1_valid_q || s1_done;
  assign desc_valid_o = s1_valid_q && (s1_q.mask != 16'd0);
  assign s1_valid_d   = in_ready_o ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: palettes
  always_comb begin
    desc_o.bcol = s1_q.bcol;
    desc_o.brow = s1_q.brow;
    desc_o.mask = s1_q.mask;
    desc_o.cidx = s1_q.cidx;
    desc_o.aidx = s1_q.aidx;
    desc_o.dxt5 = s1_q.dxt5;
    desc_o.red[0]   = s1_q.e0[0];
    desc_o.green[0] = s1_q.e0[1];
    desc_o.blue[0]  = s1_q.e0[2];
    desc_o.red[1]   = s1_q.e1[0];
    desc_o.green[1] = s1_q.e1[1];
    desc_o.blue[1]  = s1_q.e1[2];
    desc_o.apal = {4{8'd255}};
    if (s1_q.four) begin
      desc_o.red[2]   = div3({1'b0, s1_q.e0[0], 1'b0} + 10'(s1_q.e1[0]));
      desc_o.green[2] = div3({1'b0, s1_q.e0[1], 1'b0} + 10'(s1_q.e1[1]));
      desc_o.blue[2]  = div3({1'b0, s1_q.e0[2], 1'b0} + 10'(s1_q.e1[2]));
      desc_o.red[3]   = div3(10'(s1_q.e0[0]) + {1'b0, s1_q.e1[0], 1'b0});
      desc_o.green[3] = div3(10'(s1_q.e0[1]) + {1'b0, s1_q.e1[1], 1'b0});
      desc_o.blue[3]  = div3(10'(s1_q.e0[2]) + {1'b0, s1_q.e1[2], 1'b0});
    end else begin
      desc_o.red[2]   = 8'((9'(s1_q.e0[0]) + 9'(s1_q.e1[0])) >> 1);
      desc_o.green[2] = 8'((9'(s1_q.e0[1]) + 9'(s1_q.e1[1])) >> 1);
      desc_o.blue[2]  = 8'((9'(s1_q.e0[2]) + 9'(s1_q.e1[2])) >> 1);
      desc_o.red[3]   = 8'd0;
      desc_o.green[3] = 8'd0;
      desc_o.blue[3]  = 8'd0;
      desc_o.apal[3]  = 8'd0;
    end
    desc_o.av[0] = s1_q.a0;
    desc_o.av[1] = s1_q.a1;
    if (s1_q.a0 > s1_q.a1) begin
      for (int k = 1; k <= 6; k++) begin
        desc_o.av[k+1] = div7(11'((7 - k) * int'(s1_q.a0) + k * int'(s1_q.a1)));
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        desc_o.av[k+1] = div5(11'((5 - k) * int'(s1_q.a0) + k * int'(s1_q.a1)));
      end
      desc_o.av[6] = 8'd0;
      desc_o.av[7] = 8'd255;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dbd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module dbd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              ready_o,
  input  wire dbd_pkg::blk_desc_t wdata_i,
  output logic              valid_o,
  input  wire logic         pop_i,
  output dbd_pkg::blk_desc_t rdata_o
);
  import dbd_pkg::*;

  blk_desc_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dbd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire dbd_pkg::blk_desc_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [63:0]        out_data_o,
  output logic               out_last_o
);
  import dbd_pkg::*;

  logic [15:0] done_q, done_d, remain, sel_bit;
  logic [3:0]  sel;
  logic        is_last, advance;
  logic [1:0]  ci;
  logic [2:0]  ai;
  logic [7:0]  alpha;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q;
  logic        out_last_q;

  assign remain = head_i.mask & ~done_q;

  // lowest pending pixel
  always_comb begin
    sel = '0;
    for (int p = 15; p >= 0; p--) begin
      if (remain[p]) begin
        sel = 4'(p);
      end
    end
  end

  assign sel_bit = 16'd1 << sel;
  assign is_last = (remain & ~sel_bit) == 16'd0;
  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && is_last;
  assign ci      = head_i.cidx[{sel, 1'b0} +: 2];
  assign ai      = head_i.aidx[6'(sel) * 6'd3 +: 3];
  assign alpha   = head_i.dxt5 ? head_i.av[ai] : head_i.apal[ci];

  always_comb begin
    done_d = done_q;
    if (advance) begin
      done_d = is_last ? 16'd0 : (done_q | sel_bit);
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {4'd0, alpha, head_i.blue[ci], head_i.green[ci], head_i.red[ci],
                     head_i.brow, sel[3:2], head_i.bcol, sel[1:0]};
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

>>> hdl/dxt1_dxt5_block_decoder_top.sv
// channel    dir  handshake                  content
// s_axis     in   tvalid / tready            one compressed 4x4 block
// m_axis     out  tvalid / tready / tlast    one decoded pixel, tlast on block end
// apb        in   psel / penable / pready    format, width, height registers
// a block yields one pixel per cycle on m_axis while m_axis_tready is high,
// from the single pixel output register of the back end
// a first pixel passes the front-end register, the block queue and the output register;
// a two-entry block queue lets s_axis keep accepting while m_axis stalls, until the queue fills
// fully clipped blocks give no transfer and are dropped in the front end
// reset selects DXT1 and a 256 x 256 image; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none
module dxt1_dxt5_block_decoder_top #(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 16384
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // block_col[11:0], block_row[23:12], color_half[87:24], alpha_half[151:88]
  input  wire logic [151:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pixel_x[13:0], pixel_y[27:14], red[35:28], green[43:36], blue[51:44],
  // alpha[59:52], zero[63:60]
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dbd_pkg::*;

  logic                 format_q;
  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0]     width_lim, height_lim;
  logic                 cfg_wr;
  reg_idx_e             reg_idx;

  logic      desc_valid, fifo_ready, head_valid, pop;
  blk_desc_t desc, head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= 1'b0;
      width_q  <= CFG_DIM_W'(256);
      height_q <= CFG_DIM_W'(256);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FORMAT: format_q <= pwdata[0];
        REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = {31'd0, format_q};
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = 32'd0;
    endcase
  end

  assign width_lim  = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
  assign height_lim = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(height_q);

  dbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .block_col_i  (s_axis_tdata[11:0]),
    .block_row_i  (s_axis_tdata[23:12]),
    .color_half_i (s_axis_tdata[87:24]),
    .alpha_half_i (s_axis_tdata[151:88]),
    .dxt5_i       (format_q),
    .width_lim_i  (width_lim),
    .height_lim_i (height_lim),
    .desc_valid_o (desc_valid),
    .desc_ready_i (fifo_ready),
    .desc_o       (desc)
  );

  dbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_valid),
    .ready_o (fifo_ready),
    .wdata_i (desc),
    .valid_o (head_valid),
    .pop_i   (pop),
    .rdata_o (head)
  );

  dbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> hdl/dbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "dxt1_dxt5_block_decoder_top_assert.svh"
module dbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  `DBD_ASSERT_HOLD(a_out_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid)
  `DBD_ASSERT_HOLD(a_out_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  // inside a block the next pixel is ready right away
  `DBD_ASSERT_NEXT(a_block_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
  // pixels of one block share the block row
  `DBD_ASSERT_NEXT(a_block_same_row, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tdata[27:16] == $past(m_axis_tdata[27:16]))

endmodule

bind dxt1_dxt5_block_decoder_top dbd_checker u_dbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> tb/dxt1_dxt5_block_decoder_checker.sv
`timescale 1ns / 1ps
module dxt1_dxt5_block_decoder_checker
  import dbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 16384
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // block_col[11:0], block_row[23:12], color_half[87:24], alpha_half[151:88]
  input  logic [151:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x[13:0], pixel_y[27:14], red[35:28], green[43:36], blue[51:44],
  // alpha[59:52], zero[63:60]
  input  logic [63:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int unsigned  fail_cnt_o,
  output int unsigned  pending_o,
  output int unsigned  pixels_seen_o
);

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last;
  } pixel_t;

  pixel_t                 expected_pixels[$];
  logic                   cfg_dxt5;
  logic [CFG_DIM_W-1:0]   cfg_width;
  logic [CFG_DIM_W-1:0]   cfg_height;
  int unsigned            mismatch_cnt;
  int unsigned            pixels_seen;

  function automatic int unsigned scale5(input int unsigned v);
    return v * 255 / 31;
  endfunction

  function automatic int unsigned scale6(input int unsigned v);
    return v * 255 / 63;
  endfunction

  task automatic decode_block(input logic [151:0] blk);
    logic [COORD_W-1:0] bcol;
    logic [COORD_W-1:0] brow;
    logic [63:0]        color;
    logic [63:0]        alpha;
    logic [15:0]        c0;
    logic [15:0]        c1;
    int unsigned        a0;
    int unsigned        a1;
    int unsigned        red_p[4];
    int unsigned        grn_p[4];
    int unsigned        blu_p[4];
    int unsigned        alp_p[4];
    int unsigned        alv[8];
    int unsigned        wlim;
    int unsigned        hlim;
    int unsigned        row;
    int unsigned        colm;
    int unsigned        k;
    int unsigned        p;
    int unsigned        x;
    int unsigned        y;
    logic [1:0]         ci;
    logic [2:0]         ai;
    pixel_t             pix;
    pixel_t             block_pixels[$];

    bcol  = blk[11:0];
    brow  = blk[23:12];
    color = blk[87:24];
    alpha = blk[151:88];
    c0    = color[15:0];
    c1    = color[31:16];
    wlim  = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    hlim  = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;

    red_p[0] = scale5(c0[15:11]);
    grn_p[0] = scale6(c0[10:5]);
    blu_p[0] = scale5(c0[4:0]);
    red_p[1] = scale5(c1[15:11]);
    grn_p[1] = scale6(c1[10:5]);
    blu_p[1] = scale5(c1[4:0]);
    for (k = 0; k < 4; k++) alp_p[k] = 255;
    if (cfg_dxt5 || c0 > c1) begin
      red_p[2] = (2 * red_p[0] + red_p[1]) / 3;
      grn_p[2] = (2 * grn_p[0] + grn_p[1]) / 3;
      blu_p[2] = (2 * blu_p[0] + blu_p[1]) / 3;
      red_p[3] = (red_p[0] + 2 * red_p[1]) / 3;
      grn_p[3] = (grn_p[0] + 2 * grn_p[1]) / 3;
      blu_p[3] = (blu_p[0] + 2 * blu_p[1]) / 3;
    end else begin
      // three colours plus transparent black
      red_p[2] = (red_p[0] + red_p[1]) / 2;
      grn_p[2] = (grn_p[0] + grn_p[1]) / 2;
      blu_p[2] = (blu_p[0] + blu_p[1]) / 2;
      red_p[3] = 0;
      grn_p[3] = 0;
      blu_p[3] = 0;
      alp_p[3] = 0;
    end

    a0 = alpha[7:0];
    a1 = alpha[15:8];
    alv[0] = a0;
    alv[1] = a1;
    if (a0 > a1) begin
      for (k = 1; k <= 6; k++) alv[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (k = 1; k <= 4; k++) alv[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      alv[6] = 0;
      alv[7] = 255;
    end

    for (row = 0; row < 4; row++) begin
      for (colm = 0; colm < 4; colm++) begin
        x = bcol * 4 + colm;
        y = brow * 4 + row;
        p = row * 4 + colm;
        if (x >= wlim || y >= hlim) continue;
        ci = color[32 + 2 * p +: 2];
        ai = alpha[16 + 3 * p +: 3];
        pix.x     = x[PIX_W-1:0];
        pix.y     = y[PIX_W-1:0];
        pix.red   = red_p[ci][7:0];
        pix.green = grn_p[ci][7:0];
        pix.blue  = blu_p[ci][7:0];
        pix.alpha = cfg_dxt5 ? alv[ai][7:0] : alp_p[ci][7:0];
        pix.last  = 1'b0;
        block_pixels.push_back(pix);
      end
    end
    if (block_pixels.size() != 0) block_pixels[block_pixels.size() - 1].last = 1'b1;
    foreach (block_pixels[i]) expected_pixels.push_back(block_pixels[i]);
  endtask

  task automatic report_fail(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  task automatic check_pixel(input pixel_t got, input logic [3:0] pad);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_fail($sformatf("unexpected pixel transfer x=%0d y=%0d", got.x, got.y));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
        got.green !== want.green || got.blue !== want.blue ||
        got.alpha !== want.alpha || got.last !== want.last || pad !== 4'd0)
      report_fail($sformatf(
        "pixel mismatch: exp x=%0d y=%0d rgba=%02h %02h %02h %02h last=%0b | got x=%0d y=%0d rgba=%02h %02h %02h %02h last=%0b pad=%h",
        want.x, want.y, want.red, want.green, want.blue, want.alpha, want.last,
        got.x, got.y, got.red, got.green, got.blue, got.alpha, got.last, pad));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dxt5     = 1'b0;
      cfg_width    = CFG_DIM_W'(256);
      cfg_height   = CFG_DIM_W'(256);
      mismatch_cnt = 0;
      pixels_seen  = 0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_FORMAT: cfg_dxt5   = pwdata[0];
          REG_WIDTH:  cfg_width  = pwdata[CFG_DIM_W-1:0];
          REG_HEIGHT: cfg_height = pwdata[CFG_DIM_W-1:0];
          default: ;
        endcase
      end
      // compare first so a result never matches the block accepted at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen++;
        check_pixel({m_axis_tdata[13:0], m_axis_tdata[27:14], m_axis_tdata[35:28],
                     m_axis_tdata[43:36], m_axis_tdata[51:44], m_axis_tdata[59:52],
                     m_axis_tlast}, m_axis_tdata[63:60]);
      end
      if (s_axis_tvalid && s_axis_tready) decode_block(s_axis_tdata);
    end
    fail_cnt_o    <= mismatch_cnt;
    pending_o     <= expected_pixels.size();
    pixels_seen_o <= pixels_seen;
  end

endmodule

>>> tb/tb_dxt1_dxt5_block_decoder_top.sv
`timescale 1ns / 1ps
module tb_dxt1_dxt5_block_decoder_top;
  import dbd_pkg::*;

  localparam int          MAX_W         = 16384;
  localparam int          MAX_H         = 16384;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // block_col[11:0], block_row[23:12], color_half[87:24], alpha_half[151:88]
  logic [151:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pixel_x[13:0], pixel_y[27:14], red[35:28], green[43:36], blue[51:44],
  // alpha[59:52], zero[63:60]
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int unsigned  fail_cnt;
  int unsigned  pending_cnt;
  int unsigned  pixel_cnt;
  int unsigned  blocks_sent = 0;
  int unsigned  n_settings = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_max = 0;
  int unsigned  cur_w = 256;
  int unsigned  cur_h = 256;
  logic         sink_hold_req = 1'b0;
  logic [151:0] directed_blocks[$];

  dxt1_dxt5_block_decoder_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dxt1_dxt5_block_decoder_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt),
    .pixels_seen_o(pixel_cnt)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [151:0] pack_block(input logic [11:0] bcol, input logic [11:0] brow,
                                              input logic [63:0] color,
                                              input logic [63:0] alpha);
    return {alpha, color, brow, bcol};
  endfunction

  function automatic logic [151:0] random_block();
    logic [11:0] bc;
    logic [11:0] br;
    logic [63:0] c;
    logic [63:0] a;
    int unsigned span_c;
    int unsigned span_r;
    span_c = (cur_w / 4 + 1 > 4095) ? 4095 : cur_w / 4 + 1;
    span_r = (cur_h / 4 + 1 > 4095) ? 4095 : cur_h / 4 + 1;
    if ($urandom_range(0, 9) < 7) begin
      bc = 12'($urandom_range(0, span_c));
      br = 12'($urandom_range(0, span_r));
    end else begin
      bc = 12'($urandom_range(0, 4095));
      br = 12'($urandom_range(0, 4095));
    end
    c = {$urandom, $urandom};
    a = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: c[31:16] = c[15:0];
      1: a[15:8] = a[7:0];
      default: ;
    endcase
    return pack_block(bc, br, c, a);
  endfunction

  task automatic send_block(input logic [151:0] blk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
    s_axis_tdata  <= blk;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    blocks_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    // clipped blocks give no transfer but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(input logic fmt, input int unsigned w, input int unsigned h);
    wait_drained();
    apb_write(REG_FORMAT, 32'(fmt));
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    cur_w = (w > MAX_W) ? MAX_W : w;
    cur_h = (h > MAX_H) ? MAX_H : h;
  endtask

  task automatic run_phase(input int unsigned n_random, input bit drain_mid,
                           input bit hold_sink);
    int unsigned i;
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    while (directed_blocks.size() != 0) send_block(directed_blocks.pop_front());
    for (i = 0; i < n_random; i++) begin
      if (drain_mid && i == n_random / 2) wait_drained();
      if (hold_sink && i == 4) sink_hold_req <= 1'b1;
      send_block(random_block());
    end
    n_settings++;
  endtask

  // output side stall pattern, plus one long hold on request
  initial begin : sink
    int unsigned hold_left;
    int unsigned tick;
    logic [15:0] stall_pat;
    hold_left = 0;
    tick = 0;
    stall_pat = '1;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (tick % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom);
        endcase
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= stall_pat[tick % 16];
      end
      tick++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d pixels still pending", cycles, pending_cnt);
    $display("tb_dxt1_dxt5_block_decoder_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: dxt1, 256 x 256
    directed_blocks.push_back(pack_block(0, 0, 64'hE4E4_E4E4_0000_FFFF, '1));
    directed_blocks.push_back(pack_block(1, 0, 64'hE4E4_E4E4_FFFF_0000, '0));
    directed_blocks.push_back(pack_block(2, 0, 64'hFFFF_FFFF_7BEF_7BEF, '0));
    directed_blocks.push_back(pack_block(63, 63, 64'h1B1B_1B1B_07E0_F800,
                                         64'h0123_4567_89AB_CDEF));
    directed_blocks.push_back(pack_block(64, 0, 64'hE4E4_E4E4_0000_FFFF, '0));
    directed_blocks.push_back(pack_block(0, 64, 64'hE4E4_E4E4_0000_FFFF, '0));
    directed_blocks.push_back(pack_block(4095, 4095, '1, '1));
    directed_blocks.push_back(pack_block(3, 5, '0, '0));
    directed_blocks.push_back(pack_block(4, 1, 64'h4E4E_4E4E_F81F_001F, '0));
    directed_blocks.push_back(pack_block(62, 2, '1, '1));
    run_phase(40, 1'b1, 1'b0);

    configure(1'b1, 16384, 16384);
    directed_blocks.push_back(pack_block(4095, 4095, 64'hE4E4_E4E4_FFFF_0000,
                                         64'hFAC6_88FA_C688_00FF));
    directed_blocks.push_back(pack_block(0, 0, 64'hE4E4_E4E4_0000_FFFF,
                                         64'hFAC6_88FA_C688_FF00));
    directed_blocks.push_back(pack_block(1, 4095, 64'h1B1B_1B1B_5555_5555,
                                         64'hFAC6_88FA_C688_8080));
    directed_blocks.push_back(pack_block(4095, 0, 64'hFFFF_FFFF_0000_FFFF, '1));
    directed_blocks.push_back(pack_block(0, 4095, '0, '0));
    directed_blocks.push_back(pack_block(2048, 1024, 64'hE4E4_E4E4_5555_5555,
                                         64'h0000_0000_0000_1040));
    run_phase(40, 1'b0, 1'b0);

    configure(1'b0, 13, 7);
    run_phase(30, 1'b0, 1'b0);

    configure(1'b1, 1, 1);
    run_phase(20, 1'b0, 1'b0);

    // oversize width is clamped to the maximum
    configure(1'b0, 32767, 16384);
    directed_blocks.push_back(pack_block(4095, 4095, 64'h9C9C_9C9C_A5A5_5A5A, '0));
    run_phase(25, 1'b0, 1'b0);

    configure(1'b1, 0, 300);
    run_phase(10, 1'b0, 1'b0);

    configure(1'b0, 300, 0);
    run_phase(10, 1'b0, 1'b0);

    configure(1'b1, 70, 45);
    run_phase(45, 1'b0, 1'b1);

    wait_drained();
    $display("%0d blocks over %0d register settings, %0d pixels compared", blocks_sent,
             n_settings, pixel_cnt);
    $display("dxt1/dxt5 palettes, edge and full clipping, zero and oversize sizes, long stall");
    if (fail_cnt == 0) begin
      $display("tb_dxt1_dxt5_block_decoder_top OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("tb_dxt1_dxt5_block_decoder_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/dbd_pkg.sv
hdl/dbd_front.sv
hdl/dbd_fifo.sv
hdl/dbd_back.sv
hdl/dxt1_dxt5_block_decoder_top.sv
hdl/dbd_checker.sv
tb/dxt1_dxt5_block_decoder_checker.sv
tb/tb_dxt1_dxt5_block_decoder_top.sv
